/* sv/shrx_pkg.sv */
// Package for the sync header frame receiver: configuration record, item record,
// phase codes, status codes and reset values. Depends on nothing.
package shrx_pkg;

    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_FIRST_HEADER   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SECOND_HEADER  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_DEVICE_ADDRESS = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_LENGTH     = 2'd3;

    localparam logic [7:0] RST_FIRST_HEADER   = 8'h55;
    localparam logic [7:0] RST_SECOND_HEADER  = 8'hAA;
    localparam logic [7:0] RST_DEVICE_ADDRESS = 8'h11;
    localparam logic [7:0] RST_MAX_LENGTH     = 8'd30;

    localparam logic [7:0] POS_MAX = 8'hFF;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;
    localparam logic [2:0] PH_CSUM = 3'd5;

    localparam logic [2:0] ST_DISCARD  = 3'd0;
    localparam logic [2:0] ST_STORED   = 3'd1;
    localparam logic [2:0] ST_GOOD     = 3'd2;
    localparam logic [2:0] ST_BAD_HDR2 = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;
    localparam logic [2:0] ST_BAD_CSUM = 3'd6;
    localparam logic [2:0] ST_TIMEOUT  = 3'd7;

    typedef struct packed {
        logic [7:0] first_header;
        logic [7:0] second_header;
        logic [7:0] device_address;
        logic [7:0] max_payload_length;
    } t_cfg;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_item;

endpackage

/* sv/shrx_cfg.sv */
// Configuration register file of the sync header frame receiver.
// Depends on shrx_pkg for the register indexes, reset values and t_cfg.
module shrx_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [shrx_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    output shrx_pkg::t_cfg                      o_cfg
);

    shrx_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header       <= shrx_pkg::RST_FIRST_HEADER;
            r_cfg.second_header      <= shrx_pkg::RST_SECOND_HEADER;
            r_cfg.device_address     <= shrx_pkg::RST_DEVICE_ADDRESS;
            r_cfg.max_payload_length <= shrx_pkg::RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                shrx_pkg::CFG_FIRST_HEADER:   r_cfg.first_header       <= i_cfg_data;
                shrx_pkg::CFG_SECOND_HEADER:  r_cfg.second_header      <= i_cfg_data;
                shrx_pkg::CFG_DEVICE_ADDRESS: r_cfg.device_address     <= i_cfg_data;
                shrx_pkg::CFG_MAX_LENGTH:     r_cfg.max_payload_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/shrx_in_reg.sv */
// Input register of the sync header frame receiver: holds one accepted transaction
// until the decode stage takes it. Depends on shrx_pkg for t_item.
module shrx_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_op,
    input  logic [7:0]      i_rx_byte,
    output logic            o_item_valid,
    output shrx_pkg::t_item o_item,
    input  logic            i_item_take
);

    logic            r_valid;
    shrx_pkg::t_item r_item;
    logic            w_load;

    assign o_in_ready = !r_valid || i_item_take;
    assign w_load     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_item_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.op      <= i_op;
            r_item.rx_byte <= i_rx_byte;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* sv/shrx_core.sv */
// Frame decode stage of the sync header frame receiver: phase, length, sum and
// position state plus the result register. Depends on shrx_pkg.
module shrx_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  shrx_pkg::t_cfg  i_cfg,
    input  logic            i_item_valid,
    input  shrx_pkg::t_item i_item,
    output logic            o_item_take,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_frame_byte,
    output logic [7:0]      o_byte_index,
    output logic [2:0]      o_status
);

    logic [2:0] r_phase;
    logic [7:0] r_bytes_left;
    logic [7:0] r_sum;
    logic [7:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_frame_byte;
    logic [7:0] r_byte_index;
    logic [2:0] r_status;

    logic [2:0] n_phase;
    logic [7:0] n_bytes_left;
    logic [7:0] n_sum;
    logic [7:0] n_pos;
    logic [7:0] n_frame_byte;
    logic [7:0] n_byte_index;
    logic [2:0] n_status;

    logic [7:0] w_b;
    logic [7:0] w_sum_take;
    logic [7:0] w_pos_take;

    assign o_item_take = i_item_valid && (!r_out_valid || i_out_ready);

    assign w_b        = i_item.rx_byte;
    assign w_sum_take = r_sum + w_b;
    assign w_pos_take = (r_pos == shrx_pkg::POS_MAX) ? r_pos : r_pos + 8'd1;

    always_comb begin
        n_phase      = shrx_pkg::PH_HUNT;
        n_bytes_left = 8'd0;
        n_sum        = 8'd0;
        n_pos        = 8'd0;
        n_frame_byte = w_b;
        n_byte_index = r_pos;
        n_status     = shrx_pkg::ST_DISCARD;
        if (i_item.op) begin
            n_frame_byte = 8'd0;
            n_status     = shrx_pkg::ST_TIMEOUT;
        end else begin
            case (r_phase)
                shrx_pkg::PH_HDR2: begin
                    if (w_b == i_cfg.second_header) begin
                        n_phase  = shrx_pkg::PH_ADDR;
                        n_sum    = w_sum_take;
                        n_pos    = w_pos_take;
                        n_status = shrx_pkg::ST_STORED;
                    end else begin
                        n_status = shrx_pkg::ST_BAD_HDR2;
                    end
                end
                shrx_pkg::PH_ADDR: begin
                    if (w_b == i_cfg.device_address) begin
                        n_phase  = shrx_pkg::PH_LEN;
                        n_sum    = w_sum_take;
                        n_pos    = w_pos_take;
                        n_status = shrx_pkg::ST_STORED;
                    end else begin
                        n_status = shrx_pkg::ST_BAD_ADDR;
                    end
                end
                shrx_pkg::PH_LEN: begin
                    if (w_b > i_cfg.max_payload_length) begin
                        n_status = shrx_pkg::ST_TOO_LONG;
                    end else begin
                        n_phase      = shrx_pkg::PH_BODY;
                        n_bytes_left = w_b;
                        n_sum        = w_sum_take;
                        n_pos        = w_pos_take;
                        n_status     = shrx_pkg::ST_STORED;
                    end
                end
                shrx_pkg::PH_BODY: begin
                    n_sum    = w_sum_take;
                    n_pos    = w_pos_take;
                    n_status = shrx_pkg::ST_STORED;
                    if (r_bytes_left == 8'd0) begin
                        n_phase = shrx_pkg::PH_CSUM;
                    end else begin
                        n_phase      = shrx_pkg::PH_BODY;
                        n_bytes_left = r_bytes_left - 8'd1;
                    end
                end
                shrx_pkg::PH_CSUM: begin
                    n_status = (w_b == r_sum) ? shrx_pkg::ST_GOOD : shrx_pkg::ST_BAD_CSUM;
                end
                default: begin
                    n_byte_index = 8'd0;
                    if (w_b == i_cfg.first_header) begin
                        n_phase  = shrx_pkg::PH_HDR2;
                        n_sum    = w_b;
                        n_pos    = 8'd1;
                        n_status = shrx_pkg::ST_STORED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= shrx_pkg::PH_HUNT;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
            r_pos        <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_item_take) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_sum        <= n_sum;
                r_pos        <= n_pos;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_frame_byte <= n_frame_byte;
            r_byte_index <= n_byte_index;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_frame_byte;
    assign o_byte_index = r_byte_index;
    assign o_status     = r_status;

endmodule

/* sv/sync_header_frame_receiver_unit.sv */
// Top level of the sync header frame receiver: configuration registers, input
// register and frame decode stage. Depends on shrx_pkg, shrx_cfg, shrx_in_reg, shrx_core.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+-----------------------------------
//   input    | i_in_valid / o_in_ready  | i_op, i_rx_byte
//   output   | o_out_valid / i_out_ready| o_frame_byte, o_byte_index, o_status
//   config   | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// Each accepted transaction passes through the input register and then the result register.
// The input register and the result register each hold one transaction, so one
// transaction is accepted every cycle while the output side keeps taking results.
// A stalled output holds both registers; the input stays ready while its register is free.
// Reset restores the register defaults and returns the receiver to header hunting.
module sync_header_frame_receiver_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_frame_byte,
    output logic [7:0]                          o_byte_index,
    output logic [2:0]                          o_status,
    input  logic                                i_cfg_we,
    input  logic [shrx_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);

    shrx_pkg::t_cfg  w_cfg;
    shrx_pkg::t_item w_item;
    logic            w_item_valid;
    logic            w_item_take;

    shrx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    shrx_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_item_take)
    );

    shrx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_status     (o_status)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sync_header_frame_receiver_unit: frames, noise, timeouts and
// register settings are driven, and every result is checked against a frame tracker.
// Depends on shrx_pkg and the receiver RTL.
module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 165;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] byte_index;
        logic [2:0] status;
    } t_frame_result;

    typedef enum int {FR_GOOD, FR_BAD_HDR2, FR_BAD_ADDR, FR_TOO_LONG, FR_BAD_CSUM, FR_CUT,
                      FR_NOISE} t_frame_kind;

    class t_frame_tracker;
        shrx_pkg::t_cfg cfg;
        logic [2:0]     phase;
        logic [7:0]     bytes_left;
        logic [7:0]     running_sum;
        logic [7:0]     frame_position;
        t_frame_result  expected_results[$];
        int unsigned    mismatches;
        int unsigned    results_checked;
        int unsigned    status_seen[8];

        function new();
            cfg = {shrx_pkg::RST_FIRST_HEADER, shrx_pkg::RST_SECOND_HEADER,
                   shrx_pkg::RST_DEVICE_ADDRESS, shrx_pkg::RST_MAX_LENGTH};
            start_hunting();
        endfunction

        function void set_reg(logic [shrx_pkg::CfgIndexWidth-1:0] index, logic [7:0] value);
            case (index)
                shrx_pkg::CFG_FIRST_HEADER:   cfg.first_header = value;
                shrx_pkg::CFG_SECOND_HEADER:  cfg.second_header = value;
                shrx_pkg::CFG_DEVICE_ADDRESS: cfg.device_address = value;
                shrx_pkg::CFG_MAX_LENGTH:     cfg.max_payload_length = value;
                default: ;
            endcase
        endfunction

        function void start_hunting();
            phase = shrx_pkg::PH_HUNT;
            bytes_left = 8'd0;
            running_sum = 8'd0;
            frame_position = 8'd0;
        endfunction

        function void add_to_frame(logic [7:0] b);
            running_sum = running_sum + b;
            if (frame_position != shrx_pkg::POS_MAX) frame_position = frame_position + 8'd1;
        endfunction

        function void take_transaction(logic op, logic [7:0] b);
            logic [7:0] position;
            logic [2:0] st;
            t_frame_result r;
            position = frame_position;
            if (op) begin
                r = {8'd0, position, shrx_pkg::ST_TIMEOUT};
                start_hunting();
            end else begin
                case (phase)
                    shrx_pkg::PH_HDR2: begin
                        if (b == cfg.second_header) begin
                            add_to_frame(b);
                            phase = shrx_pkg::PH_ADDR;
                            st = shrx_pkg::ST_STORED;
                        end else begin
                            start_hunting();
                            st = shrx_pkg::ST_BAD_HDR2;
                        end
                    end
                    shrx_pkg::PH_ADDR: begin
                        if (b == cfg.device_address) begin
                            add_to_frame(b);
                            phase = shrx_pkg::PH_LEN;
                            st = shrx_pkg::ST_STORED;
                        end else begin
                            start_hunting();
                            st = shrx_pkg::ST_BAD_ADDR;
                        end
                    end
                    shrx_pkg::PH_LEN: begin
                        if (b > cfg.max_payload_length) begin
                            start_hunting();
                            st = shrx_pkg::ST_TOO_LONG;
                        end else begin
                            add_to_frame(b);
                            bytes_left = b;
                            phase = shrx_pkg::PH_BODY;
                            st = shrx_pkg::ST_STORED;
                        end
                    end
                    shrx_pkg::PH_BODY: begin
                        add_to_frame(b);
                        if (bytes_left == 8'd0) phase = shrx_pkg::PH_CSUM;
                        else bytes_left = bytes_left - 8'd1;
                        st = shrx_pkg::ST_STORED;
                    end
                    shrx_pkg::PH_CSUM: begin
                        st = (b == running_sum) ? shrx_pkg::ST_GOOD : shrx_pkg::ST_BAD_CSUM;
                        start_hunting();
                    end
                    default: begin
                        position = 8'd0;
                        start_hunting();
                        if (b == cfg.first_header) begin
                            add_to_frame(b);
                            phase = shrx_pkg::PH_HDR2;
                            st = shrx_pkg::ST_STORED;
                        end else begin
                            st = shrx_pkg::ST_DISCARD;
                        end
                    end
                endcase
                r = {b, position, st};
            end
            status_seen[r.status]++;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] fb, logic [7:0] position, logic [2:0] st);
            t_frame_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual byte %0d index %0d %s",
                         $time, fb, position, $sformatf("status %0d", st));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                compare_field("frame_byte", 32'(want.frame_byte), 32'(fb));
                compare_field("byte_index", 32'(want.byte_index), 32'(position));
                compare_field("status", 32'(want.status), 32'(st));
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_op = 1'b0;
    logic [7:0]                         i_rx_byte = 8'd0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [7:0]                         o_frame_byte;
    logic [7:0]                         o_byte_index;
    logic [2:0]                         o_status;
    logic                               i_cfg_we = 1'b0;
    logic [shrx_pkg::CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [7:0]                         i_cfg_data = 8'd0;

    t_frame_tracker tracker = new();
    int unsigned    send_idle_pct = 16;
    int unsigned    recv_idle_pct = 83;
    int unsigned    items_sent = 0;
    int unsigned    cycle_count = 0;

    sync_header_frame_receiver_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                tracker.check_result(o_frame_byte, o_byte_index, o_status);
            end
            if (i_in_valid && o_in_ready) tracker.take_transaction(i_op, i_rx_byte);
        end
    end

    function automatic logic [7:0] other_than(logic [7:0] v);
        return v + 8'($urandom_range(1, 255));
    endfunction

    task automatic send_item(logic op, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_rx_byte <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame(t_frame_kind kind, int len);
        shrx_pkg::t_cfg c;
        logic [7:0]     frame[$];
        logic [7:0]     sum;
        int             cut;
        c = tracker.cfg;
        if (kind == FR_NOISE) begin
            send_item($urandom_range(3) == 0, 8'($urandom));
        end else begin
            frame.push_back(c.first_header);
            if (kind == FR_BAD_HDR2) begin
                frame.push_back(($urandom_range(2) == 0 && c.first_header != c.second_header) ?
                                c.first_header : other_than(c.second_header));
            end else begin
                frame.push_back(c.second_header);
                if (kind == FR_BAD_ADDR) begin
                    frame.push_back(other_than(c.device_address));
                end else begin
                    frame.push_back(c.device_address);
                    frame.push_back(8'(len));
                    if (kind != FR_TOO_LONG) begin
                        repeat (len + 1) frame.push_back(8'($urandom));
                        sum = 8'd0;
                        foreach (frame[i]) sum = sum + frame[i];
                        frame.push_back(kind == FR_BAD_CSUM ? other_than(sum) : sum);
                    end
                end
            end
            cut = (kind == FR_CUT) ? int'($urandom_range(1, frame.size() - 1)) : frame.size();
            for (int i = 0; i < cut; i++) send_item(1'b0, frame[i]);
            if (kind == FR_CUT) send_item(1'b1, 8'($urandom));
        end
    endtask

    task automatic write_reg(logic [shrx_pkg::CfgIndexWidth-1:0] index, logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        tracker.set_reg(index, value);
    endtask

    task automatic apply_setting(shrx_pkg::t_cfg c);
        write_reg(shrx_pkg::CFG_FIRST_HEADER, c.first_header);
        write_reg(shrx_pkg::CFG_SECOND_HEADER, c.second_header);
        write_reg(shrx_pkg::CFG_DEVICE_ADDRESS, c.device_address);
        write_reg(shrx_pkg::CFG_MAX_LENGTH, c.max_payload_length);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        shrx_pkg::t_cfg settings[6];
        logic [7:0]     same;
        int unsigned    target;
        int unsigned    pick;
        int             limit;
        int             len;
        t_frame_kind    kind;

        settings[0] = {shrx_pkg::RST_FIRST_HEADER, shrx_pkg::RST_SECOND_HEADER,
                       shrx_pkg::RST_DEVICE_ADDRESS, shrx_pkg::RST_MAX_LENGTH};
        settings[1] = {8'h00, 8'h00, 8'h00, 8'd0};
        settings[2] = {8'hFF, 8'hFF, 8'hFF, 8'd250};
        settings[3] = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 250))};
        settings[4] = {8'($urandom), 8'($urandom), 8'($urandom), 8'd255};
        same = 8'($urandom);
        settings[5] = {same, same, same, 8'($urandom_range(0, 250))};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_frame(FR_GOOD, 0);
        send_item(1'b0, shrx_pkg::RST_FIRST_HEADER);
        send_item(1'b0, shrx_pkg::RST_FIRST_HEADER);
        send_item(1'b0, shrx_pkg::RST_SECOND_HEADER);
        send_frame(FR_BAD_ADDR, 0);
        send_frame(FR_TOO_LONG, int'(shrx_pkg::RST_MAX_LENGTH) + 1);
        send_frame(FR_BAD_CSUM, 0);
        send_item(1'b0, shrx_pkg::RST_FIRST_HEADER);
        send_item(1'b0, shrx_pkg::RST_SECOND_HEADER);
        send_item(1'b1, 8'h00);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_until_drained();
                apply_setting(settings[p]);
            end
            case (p / 2)
                0: begin send_idle_pct = 16; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (p == 4) begin
                send_item(1'b1, 8'($urandom));
                send_frame(FR_GOOD, 255);
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                limit = int'(tracker.cfg.max_payload_length);
                pick = $urandom_range(99);
                if (pick < 55) kind = FR_GOOD;
                else if (pick < 62) kind = FR_BAD_HDR2;
                else if (pick < 69) kind = FR_BAD_ADDR;
                else if (pick < 76) kind = FR_TOO_LONG;
                else if (pick < 84) kind = FR_BAD_CSUM;
                else if (pick < 90) kind = FR_CUT;
                else kind = FR_NOISE;
                if (limit <= 32 && $urandom_range(9) == 0) len = limit;
                else len = int'($urandom_range(0, (limit < 6) ? limit : 6));
                if (kind == FR_TOO_LONG) begin
                    if (limit == 255) kind = FR_BAD_CSUM;
                    else len = int'($urandom_range(limit + 1, 255));
                end
                send_frame(kind, len);
            end
        end
        wait_until_drained();

        $display("Covered %0d transactions and %0d results over six register settings,",
                 items_sent, tracker.results_checked);
        $display("three idle patterns, %0d good frames, %0d bad checksums and %0d timeouts.",
                 tracker.status_seen[shrx_pkg::ST_GOOD],
                 tracker.status_seen[shrx_pkg::ST_BAD_CSUM],
                 tracker.status_seen[shrx_pkg::ST_TIMEOUT]);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
